>>> src/sab_pkg.sv
// Shared types and defaults for the suffix automaton builder.
// No dependencies; imported by the top level and the testbench.
package sab_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int MAX_LEN_DEF   = 2048;
    localparam int MAX_NODES_DEF = 4096;
    localparam int ALPHABET_DEF  = 26;

    // Item codes on the action field.
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_NEW,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_Q_CHK,
        ST_COPY,
        ST_RED_RD,
        ST_RED_CHK,
        ST_SET_QL,
        ST_SET_CL,
        ST_CLR,
        ST_TERM_RD,
        ST_TERM_CHK,
        ST_READ_RD,
        ST_DONE
    } t_state;

endpackage

>>> src/sab_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Write-first on a same-address collision. No dependencies.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, forwarding a write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/suffix_automaton_builder.sv
// Online suffix automaton builder. An append item walks the suffix links from the last state
// one step at a time, and when a clone is made it copies the clone's edges and redirects the
// edges that pointed at the split state. A finish item clears the terminal marks of all used
// states and then marks every state on the suffix chain of the last one. A read looks up one
// node. Each step reads memory entries through registered read ports and waits for the data.
// After reset the block writes the null and root nodes before it takes its first item.
// A finished result waits in an output register, so the next item may start while the result
// is not yet taken.
// Depends on sab_pkg and sab_ram.
module suffix_automaton_builder #(
    parameter int MAX_LEN   = sab_pkg::MAX_LEN_DEF,
    parameter int MAX_NODES = sab_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = sab_pkg::ALPHABET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_symbol,
    input  logic [11:0] i_node_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_new_state,
    output logic [11:0] o_suffix_link,
    output logic [11:0] o_clone_state,
    output logic        o_cloned,
    output logic [12:0] o_states_used,
    output logic [11:0] o_terminals_marked,
    output logic [11:0] o_transition_target,
    output logic [11:0] o_node_length,
    output logic        o_node_terminal,
    output logic        o_status
);
    import sab_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int SW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int IW     = $clog2(ALPHABET + 1);
    localparam int TDEPTH = MAX_NODES * ALPHABET;
    localparam int AW     = $clog2(TDEPTH);
    localparam int NDW    = ALPHABET + NW + LW;

    // edge memory address of (node, letter)
    function automatic logic [AW-1:0] f_taddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
        return AW'(n) * AW'(ALPHABET) + AW'(s);
    endfunction

    t_state r_state, n_state;

    // control state
    logic [CW-1:0] r_count;
    logic [NW-1:0] r_last;
    logic [LW-1:0] r_last_len;
    logic [LW-1:0] r_pos;
    logic [CW-1:0] r_clr;
    logic          r_out_valid;

    // work registers
    logic [SW-1:0]       r_sym;
    logic [NW-1:0]       r_cur;
    logic [LW-1:0]       r_cur_len;
    logic [NW-1:0]       r_p;
    logic [NW-1:0]       r_q;
    logic [LW-1:0]       r_plen;
    logic [ALPHABET-1:0] r_q_mask;
    logic [LW-1:0]       r_q_len;
    logic [NW-1:0]       r_clone;
    logic [IW-1:0]       r_i;
    logic [CW-1:0]       r_tcnt;
    logic                r_idx_ok;
    logic                r_sym_ok;

    // result being assembled
    logic [NW-1:0] r_res_new;
    logic [NW-1:0] r_res_link;
    logic [NW-1:0] r_res_clone;
    logic          r_res_cloned;
    logic [NW-1:0] r_res_target;
    logic [LW-1:0] r_res_len;
    logic          r_res_nterm;
    logic          r_res_status;

    // memory ports
    logic            nd_we;
    logic [NW-1:0]   nd_waddr, nd_raddr;
    logic [NDW-1:0]  nd_wdata, nd_rdata;
    logic            tr_we;
    logic [AW-1:0]   tr_waddr, tr_raddr;
    logic [NW-1:0]   tr_wdata, tr_rdata;
    logic            tm_we;
    logic [NW-1:0]   tm_waddr, tm_raddr;
    logic [0:0]      tm_wdata, tm_rdata;

    // node entry fields
    logic [ALPHABET-1:0] w_mask;
    logic [NW-1:0]       w_link;
    logic [LW-1:0]       w_len;
    logic [NW-1:0]       w_edge;
    logic [ALPHABET-1:0] w_bit;
    logic                w_accept;
    logic                w_drop;
    logic                w_out_free;

    assign w_mask = nd_rdata[NDW-1 -: ALPHABET];
    assign w_link = nd_rdata[LW +: NW];
    assign w_len  = nd_rdata[LW-1:0];
    assign w_edge = w_mask[r_sym] ? tr_rdata : '0;

    always_comb begin
        w_bit        = '0;
        w_bit[r_sym] = 1'b1;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_drop     = (32'(r_pos) >= MAX_LEN) || (32'(r_count) + 32'd2 > MAX_NODES)
                        || (32'(i_symbol) >= ALPHABET);

    // node memory: {edge-present mask, suffix link, length}
    sab_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    // edge targets, valid only where the node's mask bit is set
    sab_ram #(.WIDTH(NW), .DEPTH(TDEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_raddr (tr_raddr),
        .o_rdata (tr_rdata)
    );

    // terminal marks
    sab_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term_ram (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (tm_waddr),
        .i_wdata (tm_wdata),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_clr == CW'(1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    priority case (i_action)
                        ACT_APPEND: n_state = w_drop ? ST_DONE : ST_NEW;
                        ACT_FINISH: n_state = ST_CLR;
                        ACT_READ:   n_state = ST_READ_RD;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_NEW, ST_WALK_RD: n_state = ST_WALK_CHK;
            ST_WALK_CHK: begin
                if (w_edge != '0)       n_state = ST_Q_CHK;
                else if (w_link == '0)  n_state = ST_SET_CL;
                else                    n_state = ST_WALK_RD;
            end
            ST_Q_CHK: begin
                n_state = (r_plen + LW'(1) == w_len) ? ST_SET_CL : ST_COPY;
            end
            ST_COPY: begin
                if (r_i == IW'(ALPHABET)) n_state = ST_RED_RD;
            end
            ST_RED_RD: n_state = ST_RED_CHK;
            ST_RED_CHK: begin
                n_state = (w_edge == r_q && w_link != '0) ? ST_RED_RD : ST_SET_QL;
            end
            ST_SET_QL: n_state = ST_SET_CL;
            ST_SET_CL: n_state = ST_DONE;
            ST_CLR: begin
                if (r_clr == r_count - CW'(1)) n_state = ST_TERM_RD;
            end
            ST_TERM_RD: n_state = ST_TERM_CHK;
            ST_TERM_CHK: begin
                n_state = (w_link == '0) ? ST_DONE : ST_TERM_RD;
            end
            ST_READ_RD: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        nd_we    = 1'b0;
        nd_waddr = r_p;
        nd_wdata = '0;
        nd_raddr = r_p;
        tr_we    = 1'b0;
        tr_waddr = f_taddr(r_p, r_sym);
        tr_wdata = r_cur;
        tr_raddr = f_taddr(r_p, r_sym);
        tm_we    = 1'b0;
        tm_waddr = r_p;
        tm_wdata = 1'b0;
        tm_raddr = r_p;
        unique case (r_state)
            ST_INIT: begin
                nd_we    = 1'b1;
                nd_waddr = NW'(r_clr);
                tm_we    = 1'b1;
                tm_waddr = NW'(r_clr);
            end
            ST_IDLE: begin
                nd_raddr = NW'(i_node_index);
                tr_raddr = f_taddr(NW'(i_node_index), SW'(i_symbol));
                tm_raddr = NW'(i_node_index);
            end
            ST_NEW: begin
                nd_we    = 1'b1;
                nd_waddr = r_cur;
                nd_wdata = {{ALPHABET{1'b0}}, {NW{1'b0}}, r_cur_len};
                tm_we    = 1'b1;
                tm_waddr = r_cur;
            end
            ST_WALK_CHK: begin
                if (w_edge == '0) begin
                    tr_we    = 1'b1;
                    nd_we    = 1'b1;
                    nd_wdata = {w_mask | w_bit, w_link, w_len};
                end else begin
                    nd_raddr = w_edge;
                end
            end
            ST_Q_CHK: begin
                if (r_plen + LW'(1) != w_len) begin
                    nd_we    = 1'b1;
                    nd_waddr = NW'(r_count);
                    nd_wdata = {w_mask, w_link, r_plen + LW'(1)};
                    tm_we    = 1'b1;
                    tm_waddr = NW'(r_count);
                end
            end
            ST_COPY: begin
                tr_raddr = f_taddr(r_q, SW'(r_i));
                tr_we    = (r_i != '0);
                tr_waddr = f_taddr(r_clone, SW'(r_i - IW'(1)));
                tr_wdata = tr_rdata;
            end
            ST_RED_CHK: begin
                if (w_edge == r_q) begin
                    tr_we    = 1'b1;
                    tr_wdata = r_clone;
                end
            end
            ST_SET_QL: begin
                nd_we    = 1'b1;
                nd_waddr = r_q;
                nd_wdata = {r_q_mask, r_clone, r_q_len};
            end
            ST_SET_CL: begin
                nd_we    = 1'b1;
                nd_waddr = r_cur;
                nd_wdata = {{ALPHABET{1'b0}}, r_res_link, r_cur_len};
            end
            ST_CLR: begin
                tm_we    = 1'b1;
                tm_waddr = NW'(r_clr);
            end
            ST_TERM_CHK: begin
                tm_we    = 1'b1;
                tm_wdata = 1'b1;
            end
            ST_WALK_RD, ST_RED_RD, ST_TERM_RD, ST_READ_RD, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_count     <= CW'(2);
            r_last      <= NW'(1);
            r_last_len  <= '0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid: set as a result is loaded, cleared once taken
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: r_clr <= r_clr + CW'(1);
                ST_IDLE: begin
                    if (w_accept) begin
                        r_sym        <= SW'(i_symbol);
                        r_res_new    <= '0;
                        r_res_link   <= '0;
                        r_res_clone  <= '0;
                        r_res_cloned <= 1'b0;
                        r_res_target <= '0;
                        r_res_len    <= '0;
                        r_res_nterm  <= 1'b0;
                        r_res_status <= 1'b0;
                        r_tcnt       <= '0;
                        r_clr        <= '0;
                        r_p          <= r_last;
                        r_idx_ok     <= 32'(i_node_index) < 32'(r_count);
                        r_sym_ok     <= 32'(i_symbol) < ALPHABET;
                        if (i_action == ACT_APPEND) begin
                            if (w_drop) begin
                                r_res_status <= 1'b1;
                            end else begin
                                r_cur     <= NW'(r_count);
                                r_cur_len <= r_last_len + LW'(1);
                                r_count   <= r_count + CW'(1);
                            end
                        end
                        if (i_action == ACT_FINISH) r_res_new <= r_last;
                    end
                end
                ST_WALK_CHK: begin
                    if (w_edge == '0) begin
                        r_p <= w_link;
                        if (w_link == '0) r_res_link <= NW'(1);
                    end else begin
                        r_q    <= w_edge;
                        r_plen <= w_len;
                    end
                end
                ST_Q_CHK: begin
                    if (r_plen + LW'(1) == w_len) begin
                        r_res_link <= r_q;
                    end else begin
                        r_clone      <= NW'(r_count);
                        r_res_clone  <= NW'(r_count);
                        r_res_cloned <= 1'b1;
                        r_count      <= r_count + CW'(1);
                        r_q_mask     <= w_mask;
                        r_q_len      <= w_len;
                        r_i          <= '0;
                    end
                end
                ST_COPY: r_i <= r_i + IW'(1);
                ST_RED_CHK: begin
                    if (w_edge == r_q) r_p <= w_link;
                end
                ST_SET_QL: r_res_link <= r_clone;
                ST_SET_CL: begin
                    r_last     <= r_cur;
                    r_last_len <= r_cur_len;
                    r_pos      <= r_pos + LW'(1);
                    r_res_new  <= r_cur;
                    r_res_len  <= r_cur_len;
                end
                ST_CLR: r_clr <= r_clr + CW'(1);
                ST_TERM_CHK: begin
                    r_tcnt <= r_tcnt + CW'(1);
                    r_p    <= w_link;
                    if (r_tcnt == '0) r_res_link <= w_link;
                end
                ST_READ_RD: begin
                    if (r_idx_ok) begin
                        r_res_link   <= w_link;
                        r_res_target <= (r_sym_ok && w_mask[r_sym]) ? tr_rdata : '0;
                        r_res_len    <= w_len;
                        r_res_nterm  <= tm_rdata[0];
                    end
                end
                ST_NEW, ST_WALK_RD, ST_RED_RD, ST_TERM_RD, ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // output register, loaded as the result is handed over
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            o_new_state         <= 12'(r_res_new);
            o_suffix_link       <= 12'(r_res_link);
            o_clone_state       <= 12'(r_res_clone);
            o_cloned            <= r_res_cloned;
            o_states_used       <= 13'(r_count);
            o_terminals_marked  <= 12'(r_tcnt);
            o_transition_target <= 12'(r_res_target);
            o_node_length       <= 12'(r_res_len);
            o_node_terminal     <= r_res_nterm;
            o_status            <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/sab_checker.sv
// Port-level checks for the suffix automaton builder, bound to the top level.
// Depends on suffix_automaton_builder's port list.
module sab_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_new_state,
    input logic [11:0] o_clone_state,
    input logic        o_cloned,
    input logic [12:0] o_states_used,
    input logic        o_status
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_state))
        else $error("result changed while stalled");

    // no items during the node init after reset
    a_init: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("ready during init");

    // a clone is the entry right after the new state and the last one allocated
    a_clone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cloned |-> (o_clone_state == o_new_state + 12'd1)
            && (o_states_used == {1'b0, o_clone_state} + 13'd1))
        else $error("clone index mismatch");

    // a dropped append reports no states
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_cloned && o_clone_state == 12'd0
            && o_new_state == 12'd0)
        else $error("dropped append with state");

endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (.*);

>>> tb/suffix_automaton_builder_tb.sv
// Self-checking testbench for the suffix automaton builder: directed rows, then random traffic.
// Every result is checked against a behavioral automaton kept here or a typed-in answer.
// Depends on sab_pkg and the suffix_automaton_builder RTL.
module suffix_automaton_builder_tb;
    import sab_pkg::*;

    localparam int MAX_LEN   = MAX_LEN_DEF;
    localparam int MAX_NODES = MAX_NODES_DEF;
    localparam int ALPHABET  = ALPHABET_DEF;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [11:0] new_state;
        logic [11:0] suffix_link;
        logic [11:0] clone_state;
        logic        cloned;
        logic [12:0] states_used;
        logic [11:0] terminals_marked;
        logic [11:0] transition_target;
        logic [11:0] node_length;
        logic        node_terminal;
        logic        status;
    } t_result;

    typedef struct {
        t_action     act;
        logic [4:0]  sym;
        logic [11:0] idx;
        bit          typed;
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [4:0]  i_symbol;
    logic [11:0] i_node_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_new_state;
    logic [11:0] o_suffix_link;
    logic [11:0] o_clone_state;
    logic        o_cloned;
    logic [12:0] o_states_used;
    logic [11:0] o_terminals_marked;
    logic [11:0] o_transition_target;
    logic [11:0] o_node_length;
    logic        o_node_terminal;
    logic        o_status;

    suffix_automaton_builder u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_symbol           (i_symbol),
        .i_node_index       (i_node_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_new_state        (o_new_state),
        .o_suffix_link      (o_suffix_link),
        .o_clone_state      (o_clone_state),
        .o_cloned           (o_cloned),
        .o_states_used      (o_states_used),
        .o_terminals_marked (o_terminals_marked),
        .o_transition_target(o_transition_target),
        .o_node_length      (o_node_length),
        .o_node_terminal    (o_node_terminal),
        .o_status           (o_status)
    );

    // Automaton mirror
    int       sa_edge [MAX_NODES*ALPHABET];
    int       sa_link [MAX_NODES];
    int       sa_len  [MAX_NODES];
    bit       sa_term [MAX_NODES];
    int       sa_last;
    int       sa_count;
    int       sa_pos;

    t_result  pending_results[$];
    t_row     dir_rows[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  mismatches;
    int  results_seen;
    int  n_append, n_clone, n_drop, n_finish, n_read;
    int  quiet_cycles;

    // Advance the mirror by one item and return what the block must answer.
    function automatic t_result step_automaton(t_action act, int sym, int idx);
        t_result r;
        int cur, p, q, cl, guard, t, cnt;
        r = '0;
        case (act)
            ACT_APPEND: begin
                if (sa_pos >= MAX_LEN || sa_count + 2 > MAX_NODES || sym >= ALPHABET) begin
                    r.states_used = 13'(sa_count);
                    r.status = 1'b1;
                    n_drop++;
                    return r;
                end
                n_append++;
                cur = sa_count++;
                sa_len[cur] = sa_len[sa_last] + 1;
                sa_link[cur] = 0;
                sa_term[cur] = 0;
                for (int c = 0; c < ALPHABET; c++) sa_edge[cur*ALPHABET+c] = 0;
                cl = 0;
                p = sa_last;
                guard = 0;
                while (p != 0 && sa_edge[p*ALPHABET+sym] == 0 && guard < MAX_NODES) begin
                    sa_edge[p*ALPHABET+sym] = cur;
                    p = sa_link[p];
                    guard++;
                end
                if (p == 0) begin
                    sa_link[cur] = 1;
                end else begin
                    q = sa_edge[p*ALPHABET+sym];
                    if (sa_len[p] + 1 == sa_len[q]) begin
                        sa_link[cur] = q;
                    end else begin
                        // split q: clone takes its edges and shorter length
                        cl = sa_count++;
                        sa_len[cl] = sa_len[p] + 1;
                        sa_link[cl] = sa_link[q];
                        sa_term[cl] = 0;
                        for (int c = 0; c < ALPHABET; c++)
                            sa_edge[cl*ALPHABET+c] = sa_edge[q*ALPHABET+c];
                        guard = 0;
                        while (p != 0 && sa_edge[p*ALPHABET+sym] == q && guard < MAX_NODES) begin
                            sa_edge[p*ALPHABET+sym] = cl;
                            p = sa_link[p];
                            guard++;
                        end
                        sa_link[q] = cl;
                        sa_link[cur] = cl;
                        r.cloned = 1'b1;
                        n_clone++;
                    end
                end
                sa_last = cur;
                sa_pos++;
                r.new_state = 12'(cur);
                r.suffix_link = 12'(sa_link[cur]);
                r.clone_state = 12'(cl);
                r.states_used = 13'(sa_count);
                r.node_length = 12'(sa_len[cur]);
            end
            ACT_FINISH: begin
                n_finish++;
                foreach (sa_term[i]) sa_term[i] = 0;
                t = sa_last;
                cnt = 0;
                while (t != 0 && cnt < MAX_NODES) begin
                    sa_term[t] = 1;
                    cnt++;
                    t = sa_link[t];
                end
                r.new_state = 12'(sa_last);
                r.suffix_link = 12'(sa_link[sa_last]);
                r.states_used = 13'(sa_count);
                r.terminals_marked = 12'(cnt);
            end
            ACT_READ: begin
                n_read++;
                r.states_used = 13'(sa_count);
                if (idx < sa_count) begin
                    r.suffix_link = 12'(sa_link[idx]);
                    if (sym < ALPHABET)
                        r.transition_target = 12'(sa_edge[idx*ALPHABET+sym]);
                    r.node_length = 12'(sa_len[idx]);
                    r.node_terminal = sa_term[idx];
                end
            end
            default: r.states_used = 13'(sa_count);
        endcase
        return r;
    endfunction

    // Offer one item, wait for its transfer, then maybe idle.
    task automatic send_item(t_action act, int sym, int idx,
                             bit typed, t_result typed_res);
        t_result     r;
        logic [4:0]  sym_b;
        logic [11:0] idx_b;
        sym_b = 5'(sym);
        idx_b = 12'(idx);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_symbol     <= sym_b;
        i_node_index <= idx_b;
        do @(posedge i_clk); while (!o_in_ready);
        r = step_automaton(act, int'(sym_b), int'(idx_b));
        pending_results = {pending_results, (typed ? typed_res : r)};
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // One random item: mostly appends over a narrow alphabet so clones are frequent.
    task automatic send_random();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 78) begin
            s = $urandom_range(99);
            if (s < 60) send_item(ACT_APPEND, $urandom_range(0, 2), $urandom, 0, '0);
            else if (s < 95) send_item(ACT_APPEND, $urandom_range(0, 25), $urandom, 0, '0);
            else send_item(ACT_APPEND, $urandom_range(26, 31), $urandom, 0, '0);
        end else if (r < 81) begin
            send_item(ACT_FINISH, $urandom, $urandom, 0, '0);
        end else if (r < 97) begin
            if ($urandom_range(3) != 0)
                send_item(ACT_READ, $urandom_range(0, 25), $urandom_range(0, sa_count - 1),
                          0, '0);
            else
                send_item(ACT_READ, $urandom, $urandom, 0, '0);
        end else begin
            send_item(ACT_NONE, $urandom, $urandom, 0, '0);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_new_state, o_suffix_link, o_clone_state, o_cloned, o_states_used,
                    o_terminals_marked, o_transition_target, o_node_length,
                    o_node_terminal, o_status};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch\n  exp %p\n  got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int idle_set [4][2];
        idle_set = '{'{0, 0}, '{73, 0}, '{0, 73}, '{12, 12}};
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_NONE;
        i_symbol     <= '0;
        i_node_index <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        mismatches = 0;
        results_seen = 0;
        quiet_cycles = 0;
        n_append = 0; n_clone = 0; n_drop = 0; n_finish = 0; n_read = 0;
        foreach (sa_edge[i]) sa_edge[i] = 0;
        foreach (sa_link[i]) begin
            sa_link[i] = 0;
            sa_len[i] = 0;
            sa_term[i] = 0;
        end
        sa_last = 1;
        sa_count = 2;
        sa_pos = 0;

        // Directed rows; fresh-state answers are typed in
        dir_rows = '{
            '{ACT_READ,   5'd0,  12'd1,    1, '{0, 0, 0, 0, 2, 0, 0, 0, 0, 0}},
            '{ACT_READ,   5'd31, 12'd4095, 1, '{0, 0, 0, 0, 2, 0, 0, 0, 0, 0}},
            '{ACT_NONE,   5'd31, 12'd4095, 1, '{0, 0, 0, 0, 2, 0, 0, 0, 0, 0}},
            '{ACT_APPEND, 5'd31, 12'd0,    1, '{0, 0, 0, 0, 2, 0, 0, 0, 0, 1}},
            '{ACT_APPEND, 5'd26, 12'd0,    1, '{0, 0, 0, 0, 2, 0, 0, 0, 0, 1}},
            '{ACT_APPEND, 5'd25, 12'd0,    1, '{2, 1, 0, 0, 3, 0, 0, 1, 0, 0}},
            '{ACT_FINISH, 5'd0,  12'd0,    1, '{2, 1, 0, 0, 3, 2, 0, 0, 0, 0}},
            '{ACT_READ,   5'd25, 12'd1,    1, '{0, 0, 0, 0, 3, 0, 2, 0, 1, 0}},
            '{ACT_APPEND, 5'd0,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd1,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd2,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd1,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd2,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd0,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd0,  12'd0,    0, '0},
            '{ACT_APPEND, 5'd0,  12'd0,    0, '0},
            '{ACT_FINISH, 5'd0,  12'd0,    0, '0},
            '{ACT_FINISH, 5'd31, 12'd4095, 0, '0},
            '{ACT_READ,   5'd2,  12'd4,    0, '0},
            '{ACT_READ,   5'd0,  12'd0,    0, '0},
            '{ACT_READ,   5'd31, 12'd3,    0, '0},
            '{ACT_READ,   5'd1,  12'd9,    0, '0},
            '{ACT_APPEND, 5'd25, 12'd4095, 0, '0},
            '{ACT_READ,   5'd0,  12'd2048, 0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].sym, dir_rows[i].idx,
                      dir_rows[i].typed, dir_rows[i].res);

        // Random phases over the idling mixes; first one starts with a long result hold
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            if (ph == 0) hold_req = 1'b1;
            repeat (425) send_random();
        end

        // Closing traffic: a finish over the whole string, then a few random items
        send_idle_pct = 12;
        recv_stall_pct = 12;
        send_item(ACT_FINISH, 0, 0, 0, '0);
        repeat (20) send_random();
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d appends (%0d clones), %0d dropped appends, %0d finishes, %0d reads",
                 n_append, n_clone, n_drop, n_finish, n_read);
        $display("%0d results checked, %0d mismatches, %0d states at the end",
                 results_seen, mismatches, sa_count);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
